// ===== design/mef_pkg.sv =====
package mef_pkg;

  localparam int FLOW_BITS = 22;
  localparam logic [FLOW_BITS-1:0] FLOW_MAX = 22'h3FFFFF;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_SINK   = 2'd1;
  localparam logic [1:0] REG_NODES  = 2'd2;

  typedef struct packed {
    logic clr_wr;
    logic load_wr;
    logic bfs_init;
    logic deq_rd;
    logic deq_take;
    logic scan_step;
    logic walk_init;
    logic par_rd;
    logic res_rd_uv;
    logic neck_upd;
    logic res_wr_fwd;
    logic res_rd_vu;
    logic res_wr_rev;
    logic step_adv;
    logic total_add;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic pair_ok;
    logic q_empty;
    logic found;
    logic scan_done;
    logic walk_done;
    logic out_busy;
  } status_t;

endpackage

// ===== design/max_flow_edmonds_karp.sv =====
// Sequence: edge beats load while idle. After the last-edge beat, the START state checks the
//   pair; each BFS scans the residual row of each dequeued node (one residual read a cycle
//   through the single store port); each path found is walked for its bottleneck and augmented.
// Throughput: one edge beat per cycle between runs; one result per run.
// Reset: rst (sync, active high) clears control and starts a clearing pass over the
//   NODE_LIMIT*NODE_LIMIT residual entries; the same pass follows each result.
module max_flow_edmonds_karp #(
  parameter int NODE_LIMIT = 64,
  parameter int CAP_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  // edge beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  edge_from,
  input  logic [5:0]  edge_to,
  input  logic [15:0] edge_capacity,
  input  logic        last_edge,
  // result beat
  output logic        out_valid,
  input  logic        out_stall,
  output logic [21:0] total_flow
);

  // controller sequences clear / load / BFS / walk / augment; datapath owns the stores
  mef_pkg::cmd_t    cmd;
  mef_pkg::status_t sts;

  mef_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_edge (last_edge),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  mef_datapath #(
    .NODE_LIMIT (NODE_LIMIT),
    .CAP_BITS   (CAP_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .edge_from     (edge_from),
    .edge_to       (edge_to),
    .edge_capacity (edge_capacity),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .total_flow    (total_flow)
  );

endmodule

// ===== design/mef_ctrl.sv =====
module mef_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             last_edge,
  input  mef_pkg::status_t sts,
  output mef_pkg::cmd_t    cmd,
  output logic             in_stall
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_START = 5'd2;
  localparam logic [4:0] S_INIT  = 5'd3;
  localparam logic [4:0] S_DEQ   = 5'd4;
  localparam logic [4:0] S_DEQW  = 5'd5;
  localparam logic [4:0] S_SCAN  = 5'd6;
  localparam logic [4:0] S_WINIT = 5'd7;
  localparam logic [4:0] S_W0    = 5'd8;
  localparam logic [4:0] S_W2    = 5'd9;
  localparam logic [4:0] S_W3    = 5'd10;
  localparam logic [4:0] S_AINIT = 5'd11;
  localparam logic [4:0] S_A0    = 5'd12;
  localparam logic [4:0] S_A2    = 5'd13;
  localparam logic [4:0] S_A3    = 5'd14;
  localparam logic [4:0] S_A4    = 5'd15;
  localparam logic [4:0] S_A5    = 5'd16;
  localparam logic [4:0] S_ADD   = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = !sts.clr_done;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load_wr = in_valid;
        if (in_valid && last_edge) state_next = S_START;
      end
      S_START: state_next = sts.pair_ok ? S_INIT : S_FIN;
      S_INIT: begin
        cmd.bfs_init = 1'b1;
        state_next = S_DEQ;
      end
      S_DEQ: begin
        if (sts.q_empty) begin
          state_next = S_FIN;
        end else begin
          cmd.deq_rd = 1'b1;
          state_next = S_DEQW;
        end
      end
      S_DEQW: begin
        cmd.deq_take = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        priority if (sts.found) state_next = S_WINIT;
        else if (sts.scan_done) state_next = S_DEQ;
      end
      S_WINIT: begin
        cmd.walk_init = 1'b1;
        state_next = S_W0;
      end
      S_W0: begin
        if (sts.walk_done) begin
          state_next = S_AINIT;
        end else begin
          cmd.par_rd = 1'b1;
          state_next = S_W2;
        end
      end
      S_W2: begin
        cmd.res_rd_uv = 1'b1;
        state_next = S_W3;
      end
      S_W3: begin
        cmd.neck_upd = 1'b1;
        cmd.step_adv = 1'b1;
        state_next = S_W0;
      end
      S_AINIT: begin
        cmd.walk_init = 1'b1;
        state_next = S_A0;
      end
      S_A0: begin
        if (sts.walk_done) begin
          state_next = S_ADD;
        end else begin
          cmd.par_rd = 1'b1;
          state_next = S_A2;
        end
      end
      S_A2: begin
        cmd.res_rd_uv = 1'b1;
        state_next = S_A3;
      end
      S_A3: begin
        cmd.res_wr_fwd = 1'b1;
        state_next = S_A4;
      end
      S_A4: begin
        cmd.res_rd_vu = 1'b1;
        state_next = S_A5;
      end
      S_A5: begin
        cmd.res_wr_rev = 1'b1;
        cmd.step_adv = 1'b1;
        state_next = S_A0;
      end
      S_ADD: begin
        cmd.total_add = 1'b1;
        state_next = S_INIT;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_CLEAR;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// ===== design/mef_datapath.sv =====
module mef_datapath #(
  parameter int NODE_LIMIT = 64,
  parameter int CAP_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  mef_pkg::cmd_t    cmd,
  output mef_pkg::status_t sts,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [6:0]       cfg_data,
  input  logic [5:0]       edge_from,
  input  logic [5:0]       edge_to,
  input  logic [15:0]      edge_capacity,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [21:0]      total_flow
);

  localparam int NB    = $clog2(NODE_LIMIT);
  localparam int NW    = $clog2(NODE_LIMIT + 1);
  localparam int DEPTH = NODE_LIMIT * NODE_LIMIT;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = CAP_BITS + 1;

  // config registers
  logic [5:0] source_node, sink_node;
  logic [6:0] node_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_node <= 6'd0;
      sink_node   <= 6'd63;
      node_count  <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mef_pkg::REG_SOURCE: source_node <= cfg_data[5:0];
        mef_pkg::REG_SINK:   sink_node   <= cfg_data[5:0];
        mef_pkg::REG_NODES:  node_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NW-1:0] n_lim;
  logic [NB-1:0] s_idx, t_idx;

  assign n_lim = (32'(node_count) > 32'(NODE_LIMIT)) ? NW'(NODE_LIMIT) : NW'(node_count);
  assign s_idx = NB'(source_node);
  assign t_idx = NB'(sink_node);
  assign sts.pair_ok = (32'(source_node) < 32'(n_lim)) && (32'(sink_node) < 32'(n_lim))
                       && (source_node != sink_node);

  // residual store
  logic [RW-1:0] res_mem [DEPTH];
  logic [RW-1:0] rdata, wdata;
  logic [AW-1:0] addr;
  logic          we;
  logic [AW:0]   clr_cnt;

  logic [NB-1:0] u, v, wu, p_rd, q_rd, rd_v;
  logic [NW-1:0] scan_v, head, tail, steps;
  logic          rd_vld, hit, issue, first;
  logic [RW-1:0] neck, load_val;
  logic [47:0]   cap_ext;
  logic [NODE_LIMIT-1:0] visited;
  logic [NB-1:0] parent_mem [NODE_LIMIT];
  logic [NB-1:0] queue_mem [NODE_LIMIT];
  logic [21:0]   total;
  logic [33:0]   sum;
  logic          load_ok;

  assign cap_ext  = {32'd0, edge_capacity};
  assign load_val = RW'(cap_ext & ((48'd1 << CAP_BITS) - 48'd1));
  assign load_ok  = (32'(edge_from) < 32'(NODE_LIMIT)) && (32'(edge_to) < 32'(NODE_LIMIT));
  assign issue    = cmd.scan_step && (scan_v < n_lim);

  always_comb begin
    addr  = clr_cnt[AW-1:0];
    wdata = '0;
    we    = 1'b0;
    priority if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.load_wr) begin
      addr  = AW'(32'(edge_from) * NODE_LIMIT + 32'(edge_to));
      wdata = load_val;
      we    = load_ok;
    end else if (cmd.scan_step) begin
      addr = AW'(32'(u) * NODE_LIMIT + 32'(scan_v));
    end else if (cmd.res_rd_uv) begin
      addr = AW'(32'(p_rd) * NODE_LIMIT + 32'(v));
    end else if (cmd.res_wr_fwd) begin
      addr  = AW'(32'(wu) * NODE_LIMIT + 32'(v));
      wdata = rdata - neck;
      we    = 1'b1;
    end else if (cmd.res_rd_vu || cmd.res_wr_rev) begin
      addr  = AW'(32'(v) * NODE_LIMIT + 32'(wu));
      wdata = rdata + neck;
      we    = cmd.res_wr_rev;
    end else begin
      addr = clr_cnt[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) res_mem[addr] <= wdata;
    rdata <= res_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end
  assign sts.clr_done = (clr_cnt == (AW+1)'(DEPTH));

  // breadth-first search
  assign hit = cmd.scan_step && rd_vld && !visited[rd_v] && (rdata != '0);
  assign sts.found     = hit && (rd_v == t_idx);
  assign sts.scan_done = (scan_v >= n_lim) && !rd_vld;
  assign sts.q_empty   = (head == tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      head    <= '0;
      tail    <= '0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.bfs_init) begin
        visited <= {{(NODE_LIMIT-1){1'b0}}, 1'b1} << s_idx;
        head    <= '0;
        tail    <= NW'(1);
      end else if (cmd.deq_take) begin
        head <= head + 1'b1;
      end else if (hit && !sts.found) begin
        visited[rd_v] <= 1'b1;
        if (tail < NW'(NODE_LIMIT)) tail <= tail + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bfs_init) begin
      queue_mem[0] <= s_idx;
    end else if (hit && !sts.found && (tail < NW'(NODE_LIMIT))) begin
      queue_mem[tail[NB-1:0]] <= rd_v;
    end
    if (cmd.deq_rd) q_rd <= queue_mem[head[NB-1:0]];
    if (hit) parent_mem[rd_v] <= u;
    if (cmd.par_rd) p_rd <= parent_mem[v];
  end

  always_ff @(posedge clk) begin
    if (cmd.deq_take) begin
      u      <= q_rd;
      scan_v <= '0;
    end else if (issue) begin
      scan_v <= scan_v + 1'b1;
    end
    if (issue) rd_v <= scan_v[NB-1:0];
  end

  // path walk and augmentation
  assign sts.walk_done = (v == s_idx) || (steps >= n_lim);

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      v     <= t_idx;
      steps <= '0;
      first <= 1'b1;
    end else if (cmd.step_adv) begin
      v     <= wu;
      steps <= steps + 1'b1;
    end
    if (cmd.res_rd_uv) wu <= p_rd;
    if (cmd.neck_upd && (first || rdata < neck)) begin
      neck  <= rdata;
      first <= 1'b0;
    end
  end

  assign sum = 34'(total) + 34'(neck);

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      total <= '0;
    end else if (cmd.total_add) begin
      total <= (sum > 34'(mef_pkg::FLOW_MAX)) ? mef_pkg::FLOW_MAX : sum[21:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.finish) total_flow <= total;
  end
  assign sts.out_busy = out_valid;

`ifndef SYNTHESIS
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("queue head passed tail");
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= NW'(NODE_LIMIT)) else $error("queue tail beyond depth");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_valid) else $error("result overwritten while pending");
  a_clr_bound: assert property (@(posedge clk) disable iff (rst)
    clr_cnt <= (AW+1)'(DEPTH)) else $error("clear counter overrun");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_wr |-> sts.clr_done) else $error("edge load during clear pass");
`endif

endmodule
